// ===== rtl/tetc_pkg.sv =====
// ----------------------------------------------------------------------------
// tetc_pkg: shared constants and helpers for the tensor element type cast unit
// Mode and register codes, pipeline depths and a leading-one finder.
// ----------------------------------------------------------------------------
`default_nettype none

package tetc_pkg;

    // cast modes
    localparam logic [2:0] MODE_COPY    = 3'd0;
    localparam logic [2:0] MODE_F32_F16 = 3'd1;
    localparam logic [2:0] MODE_F16_F32 = 3'd2;
    localparam logic [2:0] MODE_QUANT   = 3'd3;
    localparam logic [2:0] MODE_DEQUANT = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_CAST_MODE  = 2'd0;
    localparam logic [1:0] CFG_QUANT_SCALE = 2'd1;
    localparam logic [1:0] CFG_ZERO_POINT = 2'd2;

    localparam logic [7:0]  QMAX         = 8'd255;
    localparam logic [31:0] SCALE_RESET  = 32'h3F80_0000;
    localparam logic [31:0] F32_QNAN     = 32'h7FC0_0000;

    // pipeline depths
    localparam int DIV_STEPS = 14;               // two quotient bits per stage
    localparam int F16_LAT   = 2;
    localparam int DQ_LAT    = 5;
    localparam int Q_LAT     = DIV_STEPS + 5;    // decode, normalize, divide, 3 post
    localparam int F16_PAD   = Q_LAT - F16_LAT;
    localparam int DQ_PAD    = Q_LAT - DQ_LAT;

    // position of the highest set bit (0 when no bit is set)
    function automatic logic [4:0] msb_pos32(input logic [31:0] v);
        logic [4:0] pos;
        pos = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                pos = 5'(i);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tetc_f16_conv.sv =====
// ----------------------------------------------------------------------------
// tetc_f16_conv: fp32 <-> fp16 conversion, two register stages
// Both directions are computed for every request; the top picks one.
// ----------------------------------------------------------------------------
`default_nettype none

module tetc_f16_conv import tetc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [31:0] element_bits,
    output logic      [31:0] f16_bits,     // fp32 -> fp16 result
    output logic      [31:0] f32_bits      // fp16 -> fp32 result
);

    // ---- stage 1: fp32 -> fp16 truncation and round decision
    logic        s1_sign_reg;
    logic [14:0] s1_h_reg;
    logic        s1_inc_reg;
    logic        hs_reg;
    logic [4:0]  he_reg;
    logic [9:0]  hm_reg;
    logic [3:0]  hshift_reg;

    logic [14:0] h_next;
    logic        inc_next;
    logic [7:0]  fe;
    logic [22:0] fm;
    logic [12:0] rem13;
    logic [7:0]  sh;
    logic [23:0] full, rem24, half24;
    logic [4:0]  hpos;

    always_comb begin
        fe       = element_bits[30:23];
        fm       = element_bits[22:0];
        rem13    = fm[12:0];
        sh       = 8'd126 - fe;
        full     = {1'b1, fm};
        rem24    = full & ((24'd1 << sh[4:0]) - 24'd1);
        half24   = 24'd1 << (sh[4:0] - 5'd1);
        h_next   = 15'd0;
        inc_next = 1'b0;
        if (fe == 8'hFF) begin
            if (fm != 23'd0) begin
                h_next = 15'h7C00 | 15'h0200 | {5'd0, fm[22:13]};
            end else begin
                h_next = 15'h7C00;
            end
        end else if (fe >= 8'd143) begin
            h_next = 15'h7C00;
        end else if (fe >= 8'd113) begin
            h_next   = {5'(fe - 8'd112), fm[22:13]};
            inc_next = (rem13 > 13'h1000) || (rem13 == 13'h1000 && fm[13]);
        end else if (sh <= 8'd24) begin
            h_next   = 15'(full >> sh[4:0]);
            inc_next = (rem24 > half24) || (rem24 == half24 && h_next[0]);
        end
        // fp16 subnormal normalize distance
        hpos = msb_pos32({22'd0, element_bits[9:0]});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_sign_reg <= element_bits[31];
            s1_h_reg    <= h_next;
            s1_inc_reg  <= inc_next;
            hs_reg      <= element_bits[15];
            he_reg      <= element_bits[14:10];
            hm_reg      <= element_bits[9:0];
            hshift_reg  <= 4'd10 - hpos[3:0];
        end
    end

    // ---- stage 2: rounding increment and fp32 packing
    logic [31:0] f16_bits_reg, f32_bits_reg;
    logic [31:0] f32_next;
    logic [9:0]  hm_norm;
    logic [7:0]  ex_sub;

    always_comb begin
        hm_norm = 10'(hm_reg << hshift_reg);
        ex_sub  = 8'd113 - {4'd0, hshift_reg};
        if (he_reg == 5'h1F) begin
            if (hm_reg != 10'd0) begin
                f32_next = {hs_reg, 8'hFF, 1'b1, hm_reg[8:0], 13'd0};
            end else begin
                f32_next = {hs_reg, 8'hFF, 23'd0};
            end
        end else if (he_reg == 5'd0) begin
            if (hm_reg == 10'd0) begin
                f32_next = {hs_reg, 31'd0};
            end else begin
                f32_next = {hs_reg, ex_sub, hm_norm, 13'd0};
            end
        end else begin
            f32_next = {hs_reg, 8'({3'd0, he_reg} + 8'd112), hm_reg, 13'd0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f16_bits_reg <= {16'd0, s1_sign_reg, 15'(s1_h_reg + {14'd0, s1_inc_reg})};
            f32_bits_reg <= f32_next;
        end
    end

    assign f16_bits = f16_bits_reg;
    assign f32_bits = f32_bits_reg;

endmodule

`default_nettype wire

// ===== rtl/tetc_quant.sv =====
// ----------------------------------------------------------------------------
// tetc_quant: fp32 -> uint8 affine quantization
// Decode, normalize, 14-stage restoring divider (2 bits a stage), fp32
// rounding of the quotient, half-away rounding, zero point add and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module tetc_quant import tetc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [31:0] element_bits,
    input  wire logic [31:0] quant_scale,
    input  wire logic [7:0]  quant_zero_point,
    output logic      [7:0]  quant_bits
);

    typedef struct packed {
        logic               neg;
        logic signed [9:0]  e;
        logic               spec;
        logic [7:0]         sval;
        logic [7:0]         zp;
        logic [23:0]        ns;
    } side_t;

    // one restoring step: {quotient bit, shifted partial remainder}
    function automatic logic [25:0] div_bit(input logic [24:0] r, input logic [23:0] d);
        logic        ge;
        logic [24:0] rr;
        ge = r >= {1'b0, d};
        rr = ge ? r - {1'b0, d} : r;
        return {ge, rr[23:0], 1'b0};
    endfunction

    // ---- stage 1: decode operands and special cases
    logic        sx, ss, x_nan, s_nan, x_inf, s_inf, x_zero, s_zero, qneg;
    logic [23:0] mx, ms;
    logic [4:0]  px, ps;
    logic        spec_next;
    logic [7:0]  sval_next;
    side_t       s1_side_next;

    always_comb begin
        sx     = element_bits[31];
        ss     = quant_scale[31];
        x_nan  = element_bits[30:23] == 8'hFF && element_bits[22:0] != 23'd0;
        s_nan  = quant_scale[30:23] == 8'hFF && quant_scale[22:0] != 23'd0;
        x_inf  = element_bits[30:23] == 8'hFF && element_bits[22:0] == 23'd0;
        s_inf  = quant_scale[30:23] == 8'hFF && quant_scale[22:0] == 23'd0;
        x_zero = element_bits[30:0] == 31'd0;
        s_zero = quant_scale[30:0] == 31'd0;
        qneg   = sx ^ ss;
        mx     = {element_bits[30:23] != 8'd0, element_bits[22:0]};
        ms     = {quant_scale[30:23] != 8'd0, quant_scale[22:0]};
        px     = msb_pos32({8'd0, mx});
        ps     = msb_pos32({8'd0, ms});
        spec_next = 1'b1;
        sval_next = 8'd0;
        if (x_nan || s_nan) begin
            sval_next = 8'd0;
        end else if (s_zero) begin
            sval_next = (x_zero || qneg) ? 8'd0 : QMAX;
        end else if (x_inf) begin
            sval_next = (s_inf || qneg) ? 8'd0 : QMAX;
        end else if (s_inf || x_zero) begin
            sval_next = quant_zero_point;
        end else begin
            spec_next = 1'b0;
        end
        s1_side_next      = '0;
        s1_side_next.neg  = qneg;
        s1_side_next.spec = spec_next;
        s1_side_next.sval = sval_next;
        s1_side_next.zp   = quant_zero_point;
    end

    logic [23:0] s1_mx_reg, s1_ms_reg;
    logic [4:0]  s1_lzx_reg, s1_lzs_reg;
    logic [7:0]  s1_ex_reg, s1_es_reg;
    side_t       s1_side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_mx_reg   <= mx;
            s1_ms_reg   <= ms;
            s1_lzx_reg  <= 5'd23 - px;
            s1_lzs_reg  <= 5'd23 - ps;
            s1_ex_reg   <= (element_bits[30:23] == 8'd0) ? 8'd1 : element_bits[30:23];
            s1_es_reg   <= (quant_scale[30:23] == 8'd0) ? 8'd1 : quant_scale[30:23];
            s1_side_reg <= s1_side_next;
        end
    end

    // ---- stage 2: normalize mantissas, quotient exponent
    logic [23:0] s2_nx_reg;
    side_t       s2_side_reg;
    side_t       s2_side_next;

    always_comb begin
        s2_side_next    = s1_side_reg;
        s2_side_next.ns = s1_ms_reg << s1_lzs_reg;
        s2_side_next.e  = $signed({2'b00, s1_ex_reg}) - $signed({5'd0, s1_lzx_reg})
                        - $signed({2'b00, s1_es_reg}) + $signed({5'd0, s1_lzs_reg});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_nx_reg   <= s1_mx_reg << s1_lzx_reg;
            s2_side_reg <= s2_side_next;
        end
    end

    // ---- divider stages
    logic [24:0] dv_r_reg    [DIV_STEPS];
    logic [27:0] dv_q_reg    [DIV_STEPS];
    side_t       dv_side_reg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [24:0] r_in;
        logic [27:0] q_in;
        side_t       sd_in;
        logic [25:0] b0, b1;
        if (k == 0) begin : g_first
            assign r_in  = {1'b0, s2_nx_reg};
            assign q_in  = '0;
            assign sd_in = s2_side_reg;
        end else begin : g_next
            assign r_in  = dv_r_reg[k-1];
            assign q_in  = dv_q_reg[k-1];
            assign sd_in = dv_side_reg[k-1];
        end
        assign b0 = div_bit(r_in, sd_in.ns);
        assign b1 = div_bit(b0[24:0], sd_in.ns);
        always_ff @(posedge aclk) begin
            if (en) begin
                dv_r_reg[k]    <= b1[24:0];
                dv_q_reg[k]    <= {q_in[25:0], b0[25], b1[25]};
                dv_side_reg[k] <= sd_in;
            end
        end
    end

    // ---- post 1: round the quotient to fp32 precision
    logic [27:0]       qv;
    logic              st, g;
    logic [23:0]       sig;
    logic [24:0]       sig_r;
    logic signed [9:0] e_n;
    side_t             dsd;

    always_comb begin
        qv  = dv_q_reg[DIV_STEPS-1];
        dsd = dv_side_reg[DIV_STEPS-1];
        if (qv[27]) begin
            sig = qv[27:4];
            g   = qv[3];
            st  = (qv[2:0] != 3'd0) || (dv_r_reg[DIV_STEPS-1] != 25'd0);
            e_n = dsd.e;
        end else begin
            sig = qv[26:3];
            g   = qv[2];
            st  = (qv[1:0] != 2'd0) || (dv_r_reg[DIV_STEPS-1] != 25'd0);
            e_n = dsd.e - 10'sd1;
        end
        sig_r = {1'b0, sig} + {24'd0, g & (st | sig[0])};
    end

    logic [23:0]       p1_sig_reg;
    logic signed [9:0] p1_e_reg;
    side_t             p1_side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_sig_reg  <= sig_r[24] ? sig_r[24:1] : sig_r[23:0];
            p1_e_reg    <= sig_r[24] ? e_n + 10'sd1 : e_n;
            p1_side_reg <= dsd;
        end
    end

    // ---- post 2: round half away from zero to an integer magnitude
    logic [9:0]  rs_full;
    logic [4:0]  rs5;
    logic [24:0] isum, ishift;
    logic [9:0]  imag;
    logic        big;

    always_comb begin
        rs_full = 10'(10'sd23 - p1_e_reg);
        rs5     = rs_full[4:0];
        isum    = {1'b0, p1_sig_reg} + (25'd1 << (rs5 - 5'd1));
        ishift  = isum >> rs5;
        big     = p1_e_reg >= 10'sd9;
        if (big || p1_e_reg <= -10'sd2) begin
            imag = 10'd0;
        end else begin
            imag = ishift[9:0];
        end
    end

    logic [9:0] p2_i_reg;
    logic       p2_big_reg;
    side_t      p2_side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_i_reg    <= imag;
            p2_big_reg  <= big;
            p2_side_reg <= p1_side_reg;
        end
    end

    // ---- post 3: zero point and saturation
    logic signed [10:0] val;
    logic [7:0]         clamped;

    always_comb begin
        if (p2_side_reg.neg) begin
            val = $signed({3'd0, p2_side_reg.zp}) - $signed({1'b0, p2_i_reg});
        end else begin
            val = $signed({3'd0, p2_side_reg.zp}) + $signed({1'b0, p2_i_reg});
        end
        if (p2_big_reg) begin
            clamped = p2_side_reg.neg ? 8'd0 : QMAX;
        end else if (val > 11'sd255) begin
            clamped = QMAX;
        end else if (val < 11'sd0) begin
            clamped = 8'd0;
        end else begin
            clamped = val[7:0];
        end
    end

    logic [7:0] quant_bits_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            quant_bits_reg <= p2_side_reg.spec ? p2_side_reg.sval : clamped;
        end
    end

    assign quant_bits = quant_bits_reg;

endmodule

`default_nettype wire

// ===== rtl/tetc_dequant.sv =====
// ----------------------------------------------------------------------------
// tetc_dequant: uint8 -> fp32 affine dequantization, five register stages
// Offset, multiply, leading-one search, round, pack.
// ----------------------------------------------------------------------------
`default_nettype none

module tetc_dequant import tetc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [31:0] element_bits,
    input  wire logic [31:0] quant_scale,
    input  wire logic [7:0]  quant_zero_point,
    output logic      [31:0] dequant_bits
);

    // ---- stage 1: offset and special cases
    logic [8:0]  dd;
    logic [7:0]  mag;
    logic        dneg, sgn, s_nan, s_inf, s_zero, spec;
    logic [31:0] sval;

    always_comb begin
        dd     = {1'b0, element_bits[7:0]} - {1'b0, quant_zero_point};
        dneg   = dd[8];
        mag    = dneg ? 8'(-dd) : dd[7:0];
        sgn    = dneg ^ quant_scale[31];
        s_nan  = quant_scale[30:23] == 8'hFF && quant_scale[22:0] != 23'd0;
        s_inf  = quant_scale[30:23] == 8'hFF && quant_scale[22:0] == 23'd0;
        s_zero = quant_scale[30:0] == 31'd0;
        spec   = 1'b1;
        if (s_nan || (s_inf && mag == 8'd0)) begin
            sval = F32_QNAN;
        end else if (s_inf) begin
            sval = {sgn, 8'hFF, 23'd0};
        end else if (s_zero || mag == 8'd0) begin
            sval = {sgn, 31'd0};
        end else begin
            sval = '0;
            spec = 1'b0;
        end
    end

    logic [7:0]  d1_mag_reg;
    logic [23:0] d1_ms_reg;
    logic [7:0]  d1_es_reg;
    logic        d1_sgn_reg, d1_spec_reg;
    logic [31:0] d1_sval_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            d1_mag_reg  <= mag;
            d1_ms_reg   <= {quant_scale[30:23] != 8'd0, quant_scale[22:0]};
            d1_es_reg   <= (quant_scale[30:23] == 8'd0) ? 8'd1 : quant_scale[30:23];
            d1_sgn_reg  <= sgn;
            d1_spec_reg <= spec;
            d1_sval_reg <= sval;
        end
    end

    // ---- stage 2: product
    logic [31:0] d2_p_reg;
    logic [7:0]  d2_es_reg;
    logic        d2_sgn_reg, d2_spec_reg;
    logic [31:0] d2_sval_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            d2_p_reg    <= {24'd0, d1_mag_reg} * {8'd0, d1_ms_reg};
            d2_es_reg   <= d1_es_reg;
            d2_sgn_reg  <= d1_sgn_reg;
            d2_spec_reg <= d1_spec_reg;
            d2_sval_reg <= d1_sval_reg;
        end
    end

    // ---- stage 3: leading one
    logic [31:0] d3_p_reg;
    logic [4:0]  d3_l_reg;
    logic [7:0]  d3_es_reg;
    logic        d3_sgn_reg, d3_spec_reg;
    logic [31:0] d3_sval_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            d3_p_reg    <= d2_p_reg;
            d3_l_reg    <= msb_pos32(d2_p_reg);
            d3_es_reg   <= d2_es_reg;
            d3_sgn_reg  <= d2_sgn_reg;
            d3_spec_reg <= d2_spec_reg;
            d3_sval_reg <= d2_sval_reg;
        end
    end

    // ---- stage 4: align and round to nearest even
    logic [4:0]        rs;
    logic signed [9:0] ee;
    logic [31:0]       mshift, low, half;
    logic [24:0]       mr;
    logic              inc;

    always_comb begin
        if (d3_l_reg >= 5'd23) begin
            rs = d3_l_reg - 5'd23;
            ee = $signed({2'b00, d3_es_reg}) + $signed({5'd0, rs});
        end else begin
            rs = 5'd0;
            ee = 10'sd1;
        end
        mshift = d3_p_reg >> rs;
        low    = d3_p_reg & ((32'd1 << rs) - 32'd1);
        half   = 32'd1 << (rs - 5'd1);
        inc    = (rs != 5'd0) && ((low > half) || (low == half && mshift[0]));
        mr     = {1'b0, mshift[23:0]} + {24'd0, inc};
    end

    logic [23:0]       d4_m_reg;
    logic signed [9:0] d4_e_reg;
    logic              d4_sgn_reg, d4_spec_reg;
    logic [31:0]       d4_sval_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            d4_m_reg    <= mr[24] ? mr[24:1] : mr[23:0];
            d4_e_reg    <= mr[24] ? ee + 10'sd1 : ee;
            d4_sgn_reg  <= d3_sgn_reg;
            d4_spec_reg <= d3_spec_reg;
            d4_sval_reg <= d3_sval_reg;
        end
    end

    // ---- stage 5: pack
    logic [31:0] packed_bits;
    logic [31:0] dequant_bits_reg;

    always_comb begin
        if (d4_e_reg >= 10'sd255) begin
            packed_bits = {d4_sgn_reg, 8'hFF, 23'd0};
        end else if (d4_m_reg[23]) begin
            packed_bits = {d4_sgn_reg, d4_e_reg[7:0], d4_m_reg[22:0]};
        end else begin
            packed_bits = {d4_sgn_reg, 8'd0, d4_m_reg[22:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dequant_bits_reg <= d4_spec_reg ? d4_sval_reg : packed_bits;
        end
    end

    assign dequant_bits = dequant_bits_reg;

endmodule

`default_nettype wire

// ===== rtl/tensor_element_type_cast_unit.sv =====
// ----------------------------------------------------------------------------
// tensor_element_type_cast_unit: per-element tensor type conversion
// Depth: in every mode the delay from accepted request to result is set by
//   the quantize path (decode, normalize, 14 divider stages, 3 post stages).
// Throughput: one element per cycle; the whole pipeline holds while the
//   output register is full and not taken.
// Reset: valid bits cleared, cast_mode 0, scale 1.0, zero point 0.
// ----------------------------------------------------------------------------
`default_nettype none

module tensor_element_type_cast_unit import tetc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input elements
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,    // [31:0] element_bits
    input  wire logic        s_tlast,    // last_in
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,    // [31:0] result_bits
    output logic             m_tlast,    // last_out
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    // ---- configuration registers
    logic [2:0]  cast_mode_reg;
    logic [31:0] quant_scale_reg;
    logic [7:0]  zero_point_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cast_mode_reg   <= MODE_COPY;
            quant_scale_reg <= SCALE_RESET;
            zero_point_reg  <= 8'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CAST_MODE:   cast_mode_reg   <= cfg_data[2:0];
                CFG_QUANT_SCALE: quant_scale_reg <= cfg_data;
                CFG_ZERO_POINT:  zero_point_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ---- global advance: move when the output slot is free or taken
    logic m_valid_reg;
    logic en;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // ---- control and raw data line
    logic        vld_reg  [Q_LAT];
    logic        last_reg [Q_LAT];
    logic [2:0]  mode_reg [Q_LAT];
    logic [31:0] raw_reg  [Q_LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < Q_LAT; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int k = 1; k < Q_LAT; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            last_reg[0] <= s_tlast;
            mode_reg[0] <= cast_mode_reg;
            raw_reg[0]  <= s_tdata;
            for (int k = 1; k < Q_LAT; k++) begin
                last_reg[k] <= last_reg[k-1];
                mode_reg[k] <= mode_reg[k-1];
                raw_reg[k]  <= raw_reg[k-1];
            end
        end
    end

    // ---- conversion units
    logic [31:0] f16_bits, f32_bits, dequant_bits;
    logic [7:0]  quant_bits;

    tetc_f16_conv u_f16 (
        .aclk         (aclk),
        .en           (en),
        .element_bits (s_tdata),
        .f16_bits     (f16_bits),
        .f32_bits     (f32_bits)
    );

    tetc_quant u_quant (
        .aclk             (aclk),
        .en               (en),
        .element_bits     (s_tdata),
        .quant_scale      (quant_scale_reg),
        .quant_zero_point (zero_point_reg),
        .quant_bits       (quant_bits)
    );

    tetc_dequant u_dequant (
        .aclk             (aclk),
        .en               (en),
        .element_bits     (s_tdata),
        .quant_scale      (quant_scale_reg),
        .quant_zero_point (zero_point_reg),
        .dequant_bits     (dequant_bits)
    );

    // ---- align the short paths to the quantize depth
    logic [31:0] f16_dly_reg [F16_PAD];
    logic [31:0] f32_dly_reg [F16_PAD];
    logic [31:0] dq_dly_reg  [DQ_PAD];

    always_ff @(posedge aclk) begin
        if (en) begin
            f16_dly_reg[0] <= f16_bits;
            f32_dly_reg[0] <= f32_bits;
            for (int k = 1; k < F16_PAD; k++) begin
                f16_dly_reg[k] <= f16_dly_reg[k-1];
                f32_dly_reg[k] <= f32_dly_reg[k-1];
            end
            dq_dly_reg[0] <= dequant_bits;
            for (int k = 1; k < DQ_PAD; k++) begin
                dq_dly_reg[k] <= dq_dly_reg[k-1];
            end
        end
    end

    // ---- result select and output register
    logic [31:0] sel_bits;
    logic [31:0] m_data_reg;
    logic        m_last_reg;

    always_comb begin
        case (mode_reg[Q_LAT-1])
            MODE_F32_F16: sel_bits = f16_dly_reg[F16_PAD-1];
            MODE_F16_F32: sel_bits = f32_dly_reg[F16_PAD-1];
            MODE_QUANT:   sel_bits = {24'd0, quant_bits};
            MODE_DEQUANT: sel_bits = dq_dly_reg[DQ_PAD-1];
            default:      sel_bits = raw_reg[Q_LAT-1];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vld_reg[Q_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= sel_bits;
            m_last_reg <= last_reg[Q_LAT-1];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire
